[hw/rtl/mclc_pkg.sv]
// Package for the marker centering landing controller.
// Holds the configuration and result types, register indexes and reset values.
// No dependencies.
package mclc_pkg;

  typedef struct packed {
    logic [15:0] gain_q16;
    logic [10:0] center_radius_px;
    logic [7:0]  ticks_required;
    logic [11:0] descent_speed;
    logic [11:0] speed_limit;
    logic [15:0] fast_descent_alt_mm;
    logic [15:0] land_alt_mm;
  } cfg_t;

  typedef struct packed {
    logic [12:0] vel_north;
    logic [12:0] vel_east;
    logic [11:0] vel_down;
    logic        is_centred;
    logic        land_now;
  } result_t;

  typedef enum logic [2:0] {
    REG_GAIN        = 3'd0,
    REG_RADIUS      = 3'd1,
    REG_TICKS       = 3'd2,
    REG_DESCENT     = 3'd3,
    REG_SPEED_LIMIT = 3'd4,
    REG_FAST_ALT    = 3'd5,
    REG_LAND_ALT    = 3'd6,
    REG_NONE        = 3'd7
  } reg_index_t;

  localparam cfg_t CFG_RESET = '{
    gain_q16:            16'd131,
    center_radius_px:    11'd50,
    ticks_required:      8'd10,
    descent_speed:       12'd1229,
    speed_limit:         12'd2048,
    fast_descent_alt_mm: 16'd1000,
    land_alt_mm:         16'd300
  };

  localparam logic [7:0] COUNT_MAX = 8'd255;

endpackage

[hw/rtl/marker_centering_landing_controller.sv]
// Marker centering landing controller, top level: item and result registers,
// configuration registers and counter state. Depends on mclc_pkg and mclc_law.
//
// The block takes one control tick per clock cycle while no result waits on
// out_tready, and returns one result transaction per tick. A tick is captured
// in the input register, the velocity law and centring test run in one
// combinational pass, and the outcome lands in the result register once that
// register is free, which raises out_tvalid. The input register keeps taking
// ticks while a result waits on out_tready, up to one tick held in each
// register. The user must write configuration through the APB-style port only
// while no tick is in flight; the block itself does not enforce it.
module marker_centering_landing_controller #(
  parameter int PIXEL_ERROR_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  // tdata: error_x, error_y, altitude_mm, zero pad
  input  logic [((2*PIXEL_ERROR_BITS+16+7)/8)*8-1:0] in_tdata,
  // tuser: marker_found
  input  logic [0:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: vel_north, vel_east, vel_down, zero pad
  output logic [39:0] out_tdata,
  // tuser: is_centred, land_now
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int P = PIXEL_ERROR_BITS;

  mclc_pkg::cfg_t          cfg_r;
  mclc_pkg::reg_index_t    reg_idx;
  logic                    s1_valid_r;
  logic signed [P-1:0]     ex_r;
  logic signed [P-1:0]     ey_r;
  logic                    found_r;
  logic [15:0]             alt_r;
  logic                    out_valid_r;
  mclc_pkg::result_t       res_r;
  mclc_pkg::result_t       res_nxt;
  logic [7:0]              count_r;
  logic [7:0]              count_nxt;
  logic                    advance;
  logic                    cfg_write;

  assign reg_idx   = mclc_pkg::reg_index_t'(cfg_paddr[4:2]);
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mclc_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        mclc_pkg::REG_GAIN:        cfg_r.gain_q16            <= cfg_pwdata[15:0];
        mclc_pkg::REG_RADIUS:      cfg_r.center_radius_px    <= cfg_pwdata[10:0];
        mclc_pkg::REG_TICKS:       cfg_r.ticks_required      <= cfg_pwdata[7:0];
        mclc_pkg::REG_DESCENT:     cfg_r.descent_speed       <= cfg_pwdata[11:0];
        mclc_pkg::REG_SPEED_LIMIT: cfg_r.speed_limit         <= cfg_pwdata[11:0];
        mclc_pkg::REG_FAST_ALT:    cfg_r.fast_descent_alt_mm <= cfg_pwdata[15:0];
        mclc_pkg::REG_LAND_ALT:    cfg_r.land_alt_mm         <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mclc_pkg::REG_GAIN:        cfg_prdata = {16'd0, cfg_r.gain_q16};
      mclc_pkg::REG_RADIUS:      cfg_prdata = {21'd0, cfg_r.center_radius_px};
      mclc_pkg::REG_TICKS:       cfg_prdata = {24'd0, cfg_r.ticks_required};
      mclc_pkg::REG_DESCENT:     cfg_prdata = {20'd0, cfg_r.descent_speed};
      mclc_pkg::REG_SPEED_LIMIT: cfg_prdata = {20'd0, cfg_r.speed_limit};
      mclc_pkg::REG_FAST_ALT:    cfg_prdata = {16'd0, cfg_r.fast_descent_alt_mm};
      mclc_pkg::REG_LAND_ALT:    cfg_prdata = {16'd0, cfg_r.land_alt_mm};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ex_r    <= in_tdata[P-1:0];
      ey_r    <= in_tdata[2*P-1:P];
      alt_r   <= in_tdata[2*P+15:2*P];
      found_r <= in_tuser[0];
    end
  end

  mclc_law #(
    .PIXEL_ERROR_BITS(PIXEL_ERROR_BITS)
  ) u_law (
    .error_x      (ex_r),
    .error_y      (ey_r),
    .marker_found (found_r),
    .altitude_mm  (alt_r),
    .cfg          (cfg_r),
    .count        (count_r),
    .res          (res_nxt),
    .count_nxt    (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= 8'd0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.vel_down, res_r.vel_east, res_r.vel_north};
  assign out_tuser  = {res_r.land_now, res_r.is_centred};

endmodule

[hw/rtl/mclc_law.sv]
// Proportional velocity law, centring test and centred-tick counter update.
// Purely combinational; depends on mclc_pkg.
module mclc_law #(
  parameter int PIXEL_ERROR_BITS = 12
) (
  input  logic signed [PIXEL_ERROR_BITS-1:0] error_x,
  input  logic signed [PIXEL_ERROR_BITS-1:0] error_y,
  input  logic                               marker_found,
  input  logic [15:0]                        altitude_mm,
  input  mclc_pkg::cfg_t                     cfg,
  input  logic [7:0]                         count,
  output mclc_pkg::result_t                  res,
  output logic [7:0]                         count_nxt
);

  localparam int PW  = PIXEL_ERROR_BITS + 17;
  localparam int NW  = PIXEL_ERROR_BITS + 18;
  localparam int SQB = (2 * PIXEL_ERROR_BITS + 1 > 22) ? 2 * PIXEL_ERROR_BITS + 1 : 22;
  localparam int SQW = SQB + 1;

  logic signed [PW-1:0]  prod_x;
  logic signed [PW-1:0]  prod_y;
  logic signed [NW-1:0]  east_raw;
  logic signed [NW-1:0]  north_raw;
  logic signed [NW-1:0]  lim;
  logic signed [NW-1:0]  east_cl;
  logic signed [NW-1:0]  north_cl;
  logic signed [SQW-1:0] ex_w;
  logic signed [SQW-1:0] ey_w;
  logic signed [SQW-1:0] r_w;
  logic signed [SQW-1:0] dist2;
  logic signed [SQW-1:0] rad2;
  logic                  centred;
  logic                  low_alt;
  logic [7:0]            inc_count;

  assign prod_x = PW'(signed'({1'b0, cfg.gain_q16})) * PW'(error_x);
  assign prod_y = PW'(signed'({1'b0, cfg.gain_q16})) * PW'(error_y);

  assign east_raw  = NW'(prod_x) >>> 4;
  assign north_raw = (-NW'(prod_y)) >>> 4;
  assign lim       = NW'(signed'({1'b0, cfg.speed_limit}));

  always_comb begin
    priority if (east_raw > lim) begin
      east_cl = lim;
    end else if (east_raw < -lim) begin
      east_cl = -lim;
    end else begin
      east_cl = east_raw;
    end
    priority if (north_raw > lim) begin
      north_cl = lim;
    end else if (north_raw < -lim) begin
      north_cl = -lim;
    end else begin
      north_cl = north_raw;
    end
  end

  assign ex_w    = SQW'(error_x);
  assign ey_w    = SQW'(error_y);
  assign r_w     = SQW'(signed'({1'b0, cfg.center_radius_px}));
  assign dist2   = ex_w * ex_w + ey_w * ey_w;
  assign rad2    = r_w * r_w;
  assign centred = dist2 < rad2;

  assign low_alt   = altitude_mm < cfg.fast_descent_alt_mm;
  assign inc_count = (count == mclc_pkg::COUNT_MAX) ? count : count + 8'd1;

  always_comb begin
    res           = '0;
    res.land_now  = altitude_mm < cfg.land_alt_mm;
    count_nxt     = count;
    priority if (low_alt) begin
      res.vel_down = cfg.descent_speed;
    end else if (marker_found) begin
      res.vel_east   = east_cl[12:0];
      res.vel_north  = north_cl[12:0];
      res.is_centred = centred;
      count_nxt      = centred ? inc_count : 8'd0;
      if (count_nxt >= cfg.ticks_required) begin
        res.vel_down = cfg.descent_speed;
      end
    end else begin
      count_nxt = 8'd0;
    end
  end

endmodule

[tb/sv/marker_centering_landing_controller_test.sv]
// Self-checking testbench for the marker centering landing controller.
// Drives control ticks and APB register writes, predicts each velocity command
// in its own model of the control law, and depends on mclc_pkg and the block.
module marker_centering_landing_controller_test;

  typedef struct {
    int error_x;
    int error_y;
    bit marker_found;
    int altitude_mm;
  } tick_t;

  logic        clk;
  logic        rst_n;
  // tdata: error_x, error_y, altitude_mm
  logic [39:0] in_tdata;
  // tuser: marker_found
  logic [0:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  // tdata: vel_north, vel_east, vel_down, zero pad
  logic [39:0] out_tdata;
  // tuser: is_centred, land_now
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mclc_pkg::cfg_t    law_cfg;
  int                hover_count;
  mclc_pkg::result_t expected_cmds[$];
  int                send_idle_pct;
  int                recv_stall_pct;
  int                mismatches;
  int                ticks_sent;
  int                cmds_checked;
  int                descents_seen;
  int                reg_writes;

  marker_centering_landing_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  task automatic note_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
    end
  endtask

  function automatic mclc_pkg::result_t landing_law(tick_t t);
    longint            gain;
    longint            radius;
    longint            limit;
    longint            east;
    longint            north;
    longint            dist_sq;
    mclc_pkg::result_t cmd;
    gain   = longint'(law_cfg.gain_q16);
    radius = longint'(law_cfg.center_radius_px);
    limit  = longint'(law_cfg.speed_limit);
    cmd    = '0;
    if (t.altitude_mm < law_cfg.fast_descent_alt_mm) begin
      cmd.vel_down = law_cfg.descent_speed;
    end else if (t.marker_found) begin
      east  = (gain * t.error_x) >>> 4;
      north = (-(gain * t.error_y)) >>> 4;
      if (east > limit) east = limit;
      else if (east < -limit) east = -limit;
      if (north > limit) north = limit;
      else if (north < -limit) north = -limit;
      cmd.vel_east  = east[12:0];
      cmd.vel_north = north[12:0];
      dist_sq = longint'(t.error_x) * t.error_x + longint'(t.error_y) * t.error_y;
      if (dist_sq < radius * radius) begin
        cmd.is_centred = 1'b1;
        if (hover_count < mclc_pkg::COUNT_MAX) hover_count++;
      end else begin
        hover_count = 0;
      end
      if (hover_count >= law_cfg.ticks_required) cmd.vel_down = law_cfg.descent_speed;
    end else begin
      hover_count = 0;
    end
    cmd.land_now = (t.altitude_mm < law_cfg.land_alt_mm);
    return cmd;
  endfunction

  task automatic send_tick(tick_t t);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t.altitude_mm[15:0], t.error_y[11:0], t.error_x[11:0]};
    in_tuser  <= t.marker_found;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_cmds.push_back(landing_law(t));
    ticks_sent++;
  endtask

  task automatic send_fixed(int ex, int ey, bit found, int alt);
    tick_t t;
    t.error_x      = ex;
    t.error_y      = ey;
    t.marker_found = found;
    t.altitude_mm  = alt;
    send_tick(t);
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(mclc_pkg::reg_index_t idx, logic [31:0] value);
    logic [31:0] stored;
    case (idx)
      mclc_pkg::REG_GAIN:        stored = value & 32'hFFFF;
      mclc_pkg::REG_RADIUS:      stored = value & 32'h7FF;
      mclc_pkg::REG_TICKS:       stored = value & 32'hFF;
      mclc_pkg::REG_DESCENT:     stored = value & 32'hFFF;
      mclc_pkg::REG_SPEED_LIMIT: stored = value & 32'hFFF;
      mclc_pkg::REG_FAST_ALT:    stored = value & 32'hFFFF;
      mclc_pkg::REG_LAND_ALT:    stored = value & 32'hFFFF;
      default:                   stored = '0;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      mclc_pkg::REG_GAIN:        law_cfg.gain_q16            = stored[15:0];
      mclc_pkg::REG_RADIUS:      law_cfg.center_radius_px    = stored[10:0];
      mclc_pkg::REG_TICKS:       law_cfg.ticks_required      = stored[7:0];
      mclc_pkg::REG_DESCENT:     law_cfg.descent_speed       = stored[11:0];
      mclc_pkg::REG_SPEED_LIMIT: law_cfg.speed_limit         = stored[11:0];
      mclc_pkg::REG_FAST_ALT:    law_cfg.fast_descent_alt_mm = stored[15:0];
      mclc_pkg::REG_LAND_ALT:    law_cfg.land_alt_mm         = stored[15:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== stored) note_mismatch(idx.name(), stored, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic load_config(mclc_pkg::cfg_t c);
    settle_block();
    write_reg(mclc_pkg::REG_GAIN, 32'(c.gain_q16));
    write_reg(mclc_pkg::REG_RADIUS, 32'(c.center_radius_px));
    write_reg(mclc_pkg::REG_TICKS, 32'(c.ticks_required));
    write_reg(mclc_pkg::REG_DESCENT, 32'(c.descent_speed));
    write_reg(mclc_pkg::REG_SPEED_LIMIT, 32'(c.speed_limit));
    write_reg(mclc_pkg::REG_FAST_ALT, 32'(c.fast_descent_alt_mm));
    write_reg(mclc_pkg::REG_LAND_ALT, 32'(c.land_alt_mm));
  endtask

  function automatic tick_t hover_tick();
    tick_t t;
    int    span;
    span = law_cfg.center_radius_px * 7 / 10;
    t.error_x      = int'($urandom_range(0, 2 * span)) - span;
    t.error_y      = int'($urandom_range(0, 2 * span)) - span;
    t.marker_found = 1'b1;
    t.altitude_mm  = int'($urandom_range(law_cfg.fast_descent_alt_mm, 65535));
    return t;
  endfunction

  function automatic tick_t wild_tick();
    tick_t t;
    t.error_x      = int'($urandom_range(0, 4095)) - 2048;
    t.error_y      = int'($urandom_range(0, 4095)) - 2048;
    t.marker_found = 1'($urandom_range(0, 1));
    t.altitude_mm  = int'($urandom_range(0, 65535));
    return t;
  endfunction

  task automatic test_reset_hover();
    for (int i = 0; i < 10; i++) send_fixed(2 * i - 9, 20 - 4 * i, 1'b1, 2500);
    send_fixed(0, 0, 1'b0, 2500);
    send_fixed(-30, 25, 1'b1, 1500);
  endtask

  task automatic test_low_altitude_and_land();
    send_fixed(5, 5, 1'b1, 999);
    send_fixed(-600, 900, 1'b0, 299);
    send_fixed(800, -800, 1'b1, 300);
    send_fixed(0, 0, 1'b1, 0);
    send_fixed(1, -1, 1'b1, 1000);
  endtask

  task automatic test_extremes();
    mclc_pkg::cfg_t c;
    c = '{gain_q16: 16'd65535, center_radius_px: 11'd2047, ticks_required: 8'd0,
          descent_speed: 12'd4095, speed_limit: 12'd4095, fast_descent_alt_mm: 16'd0,
          land_alt_mm: 16'd65535};
    load_config(c);
    send_fixed(-2048, -2048, 1'b1, 65535);
    send_fixed(2047, 2047, 1'b1, 0);
    send_fixed(0, 0, 1'b1, 12345);
    send_fixed(-1, 1, 1'b0, 40000);
    send_fixed(1447, -1447, 1'b1, 20000);
    send_fixed(1448, 1448, 1'b1, 20000);
    c = '{gain_q16: 16'd0, center_radius_px: 11'd0, ticks_required: 8'd255,
          descent_speed: 12'd0, speed_limit: 12'd0, fast_descent_alt_mm: 16'd65535,
          land_alt_mm: 16'd0};
    load_config(c);
    send_fixed(5, -7, 1'b1, 65535);
    send_fixed(2047, -2048, 1'b1, 65534);
    c = '{gain_q16: 16'd1, center_radius_px: 11'd3, ticks_required: 8'd1,
          descent_speed: 12'd1, speed_limit: 12'd4095, fast_descent_alt_mm: 16'd0,
          land_alt_mm: 16'd0};
    load_config(c);
    send_fixed(-1, 1, 1'b1, 7);
    send_fixed(17, -17, 1'b1, 7);
  endtask

  task automatic test_count_saturation();
    mclc_pkg::cfg_t c;
    c = '{gain_q16: 16'($urandom_range(0, 65535)), center_radius_px: 11'd2047,
          ticks_required: 8'd255, descent_speed: 12'd3000, speed_limit: 12'd2000,
          fast_descent_alt_mm: 16'd500, land_alt_mm: 16'd100};
    load_config(c);
    repeat (260) send_tick(hover_tick());
  endtask

  task automatic test_random_phase(int n, int send_pct, int stall_pct);
    mclc_pkg::cfg_t c;
    int             sent;
    int             kind;
    int             run_len;
    c.gain_q16            = 16'($urandom_range(0, 1) ? $urandom_range(0, 400)
                                                     : $urandom_range(0, 65535));
    c.center_radius_px    = 11'($urandom_range(10, 700));
    c.ticks_required      = 8'($urandom_range(1, 12));
    c.descent_speed       = 12'($urandom_range(0, 4095));
    c.speed_limit         = 12'($urandom_range(0, 4095));
    c.fast_descent_alt_mm = 16'($urandom_range(0, 4000));
    c.land_alt_mm         = 16'($urandom_range(0, 3000));
    load_config(c);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n) begin
      kind = int'($urandom_range(0, 9));
      if (kind < 6) begin
        run_len = int'($urandom_range(1, law_cfg.ticks_required + 4));
        repeat (run_len) begin
          if ($urandom_range(0, 9) == 0) send_tick(wild_tick());
          else send_tick(hover_tick());
          sent++;
        end
      end else if (kind == 6) begin
        send_fixed(int'($urandom_range(0, 4095)) - 2048, 0, 1'b0,
                   int'($urandom_range(law_cfg.fast_descent_alt_mm, 65535)));
        sent++;
      end else if (kind == 7 && law_cfg.fast_descent_alt_mm != 0) begin
        send_fixed(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                   1'($urandom_range(0, 1)),
                   int'($urandom_range(0, law_cfg.fast_descent_alt_mm - 1)));
        sent++;
      end else begin
        send_tick(wild_tick());
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    mclc_pkg::result_t want;
    mclc_pkg::result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.vel_north  = out_tdata[12:0];
      got.vel_east   = out_tdata[25:13];
      got.vel_down   = out_tdata[37:26];
      got.is_centred = out_tuser[0];
      got.land_now   = out_tuser[1];
      if (expected_cmds.size() == 0) begin
        note_mismatch("result transaction with nothing pending", 0, 1);
      end else begin
        want = expected_cmds.pop_front();
        cmds_checked++;
        if (want.vel_down != 0) descents_seen++;
        if (got.vel_north !== want.vel_north)
          note_mismatch("vel_north", $signed(want.vel_north), $signed(got.vel_north));
        if (got.vel_east !== want.vel_east)
          note_mismatch("vel_east", $signed(want.vel_east), $signed(got.vel_east));
        if (got.vel_down !== want.vel_down)
          note_mismatch("vel_down", want.vel_down, got.vel_down);
        if (got.is_centred !== want.is_centred)
          note_mismatch("is_centred", want.is_centred, got.is_centred);
        if (got.land_now !== want.land_now)
          note_mismatch("land_now", want.land_now, got.land_now);
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    law_cfg        = mclc_pkg::CFG_RESET;
    hover_count    = 0;
    mismatches     = 0;
    ticks_sent     = 0;
    cmds_checked   = 0;
    descents_seen  = 0;
    reg_writes     = 0;
    send_idle_pct  = 12;
    recv_stall_pct = 47;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_hover();
    test_low_altitude_and_land();
    test_extremes();
    test_count_saturation();
    test_random_phase(90, 12, 47);
    test_random_phase(90, 47, 12);
    test_random_phase(90, 0, 0);

    settle_block();
    repeat (4) @(posedge clk);
    $display("Sent %0d control ticks over %0d register writes; checked %0d commands,",
             ticks_sent, reg_writes, cmds_checked);
    $display("%0d of them descending, with %0d mismatches.", descents_seen, mismatches);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
